[src/spq_pkg.sv]
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int ENTRY_W   = 2 * DATA_W;
  localparam int MSZ_W     = 5;

  localparam logic [MSZ_W-1:0] MAX_SIZE_RST = 5'd10;

  // register map, decoded on paddr[2]
  localparam logic REG_MAX_SIZE = 1'b0;

  // commands
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  // result status
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CHK,
    ST_REM_RD,
    ST_REM_OUT,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DUMP_RD,
    ST_DUMP_OUT,
    ST_RESP
  } state_t;

endpackage

[src/sorted_priority_queue_core.sv]
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-----------------------------------------
// in_       | request   | in_valid/in_stall  | in_cmd, in_new_value, in_new_priority
// out_      | result    | out_valid/out_stall| out_status, out_value, out_priority, out_last
// cfg_      | APB write | psel/penable/pready| max_size at byte address 0
//
// One request is worked on at a time; in_stall is high until it is done.
// Insert: scans from the top, moving each entry with a higher priority up one
// slot, then writes the new entry; full or empty replies skip the RAM.
// Remove: fetches slot 0, returns it, then shifts the rest down one slot.
// Dump: returns each entry in turn. Every step goes through the one RAM port pair.
// Reset (rst_n, sync) empties the queue, sets max_size to 10, leaves the RAM as is.
// A stalled result register holds the sequencer.
module sorted_priority_queue_core #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_cmd,
  input  logic signed [spq_pkg::DATA_W-1:0] in_new_value,
  input  logic signed [spq_pkg::DATA_W-1:0] in_new_priority,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic signed [spq_pkg::DATA_W-1:0] out_value,
  output logic signed [spq_pkg::DATA_W-1:0] out_priority,
  output logic                             out_last,
  // configuration
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [2:0]                       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  import spq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);       // occupancy 0..DEPTH
  localparam int XW = (CW > MSZ_W) ? CW : MSZ_W;

  state_t state_r, state_nxt;

  logic [CW-1:0]     cnt_r, cnt_nxt;            // occupancy
  logic [CW-1:0]     idx_r, idx_nxt;            // slot pointer of the sequencer
  logic [DATA_W-1:0] nv_r, nv_nxt;
  logic [DATA_W-1:0] np_r, np_nxt;
  logic [1:0]        resp_r, resp_nxt;          // status for single-result replies
  logic [MSZ_W-1:0]  max_size_r;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [DATA_W-1:0] out_prio_r, out_prio_nxt;
  logic              out_last_r, out_last_nxt;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [DATA_W-1:0]  rd_value, rd_prio;

  logic          accept, out_free, full, empty, prio_gt;
  logic [CW-1:0] idx_dec, idx_inc;
  logic [XW-1:0] cap;

  // ---------------------------------------------------------------------------
  // Entry store: {priority, value} per slot, registered read
  // ---------------------------------------------------------------------------
  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_value = ram_rdata[DATA_W-1:0];
  assign rd_prio  = ram_rdata[ENTRY_W-1:DATA_W];

  // ---------------------------------------------------------------------------
  // Shared compare / index unit and status terms
  // ---------------------------------------------------------------------------
  assign prio_gt = $signed(rd_prio) > $signed(np_r);
  assign idx_dec = idx_r - CW'(1);
  assign idx_inc = idx_r + CW'(1);

  // effective capacity: max_size limited to DEPTH
  assign cap   = (XW'(max_size_r) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(max_size_r);
  assign full  = XW'(cnt_r) >= cap;
  assign empty = (cnt_r == '0);

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_INSERT: state_nxt = full  ? ST_RESP : ST_INS_RD;
            CMD_REMOVE: state_nxt = empty ? ST_RESP : ST_REM_RD;
            CMD_DUMP:   state_nxt = empty ? ST_RESP : ST_DUMP_RD;
            default:    state_nxt = ST_IDLE;   // unused command, no result
          endcase
        end
      end
      ST_INS_RD:   state_nxt = (idx_r == '0) ? ST_RESP : ST_INS_CHK;
      ST_INS_CHK:  state_nxt = prio_gt ? ST_INS_RD : ST_RESP;
      ST_REM_RD:   state_nxt = ST_REM_OUT;
      ST_REM_OUT: begin
        if (out_free) begin
          state_nxt = ST_SHIFT_RD;
        end
      end
      ST_SHIFT_RD: state_nxt = (idx_r == cnt_r) ? ST_IDLE : ST_SHIFT_WR;
      ST_SHIFT_WR: state_nxt = ST_SHIFT_RD;
      ST_DUMP_RD:  state_nxt = ST_DUMP_OUT;
      ST_DUMP_OUT: begin
        if (out_free) begin
          state_nxt = (idx_inc == cnt_r) ? ST_IDLE : ST_DUMP_RD;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: datapath and RAM controls
  // ---------------------------------------------------------------------------
  always_comb begin
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    nv_nxt         = nv_r;
    np_nxt         = np_r;
    resp_nxt       = resp_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_prio_nxt   = out_prio_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[AW-1:0];
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = idx_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          nv_nxt   = in_new_value;
          np_nxt   = in_new_priority;
          idx_nxt  = (in_cmd == CMD_INSERT) ? cnt_r : '0;
          resp_nxt = (in_cmd != CMD_INSERT) ? STAT_EMPTY :
                     (full ? STAT_FULL : STAT_OK);
        end
      end
      ST_INS_RD: begin
        if (idx_r == '0) begin
          // scanned past the bottom: new entry goes to slot 0
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = {np_r, nv_r};
          cnt_nxt   = cnt_r + CW'(1);
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_dec[AW-1:0];
        end
      end
      ST_INS_CHK: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        if (prio_gt) begin
          // strictly larger priority moves up one slot
          ram_wdata = ram_rdata;
          idx_nxt   = idx_dec;
        end else begin
          // stable: lands after every entry with priority <= its own
          ram_wdata = {np_r, nv_r};
          cnt_nxt   = cnt_r + CW'(1);
        end
      end
      ST_REM_RD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      ST_REM_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_value_nxt  = rd_value;
          out_prio_nxt   = rd_prio;
          out_last_nxt   = 1'b1;
          idx_nxt        = CW'(1);
        end
      end
      ST_SHIFT_RD: begin
        if (idx_r == cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
        end else begin
          ram_re = 1'b1;
        end
      end
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_dec[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_inc;
      end
      ST_DUMP_RD: begin
        ram_re = 1'b1;
      end
      ST_DUMP_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_value_nxt  = rd_value;
          out_prio_nxt   = rd_prio;
          out_last_nxt   = (idx_inc == cnt_r);
          idx_nxt        = idx_inc;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_r;
          out_value_nxt  = '0;
          out_prio_nxt   = '0;
          out_last_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nv_r         <= nv_nxt;
    np_r         <= np_nxt;
    resp_r       <= resp_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_prio_r   <= out_prio_nxt;
    out_last_r   <= out_last_nxt;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= MAX_SIZE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_MAX_SIZE)) begin
      max_size_r <= cfg_pwdata[MSZ_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_SIZE) ? {{(32-MSZ_W){1'b0}}, max_size_r}
                                                      : '0;

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_value    = out_value_r;
  assign out_priority = out_prio_r;
  assign out_last     = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("occupancy above DEPTH");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |->
      ((cnt_r == $past(cnt_r) + CW'(1)) || (cnt_r + CW'(1) == $past(cnt_r))))
    else $error("occupancy moved by more than one");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("entry store written while idle");

  a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == CMD_INSERT) && full) |=> (state_r == ST_RESP) && !ram_we)
    else $error("insert on full queue touched the store");

endmodule

[src/spq_ram.sv]
module spq_ram #(
  parameter int WIDTH = spq_pkg::ENTRY_W,
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[tb/sv/spq_checker.sv]
`timescale 1ns / 100ps

module spq_checker #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [1:0]                       in_cmd,
  input  logic signed [spq_pkg::DATA_W-1:0] in_new_value,
  input  logic signed [spq_pkg::DATA_W-1:0] in_new_priority,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [1:0]                       out_status,
  input  logic signed [spq_pkg::DATA_W-1:0] out_value,
  input  logic signed [spq_pkg::DATA_W-1:0] out_priority,
  input  logic                             out_last,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [2:0]                       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  input  logic                             cfg_pready,
  output int                               fail_count,
  output int                               pending
);
  import spq_pkg::*;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
    logic                     last;
  } queue_result_t;

  queue_result_t            awaited_q[$];
  logic signed [DATA_W-1:0] slot_val [DEPTH];
  logic signed [DATA_W-1:0] slot_pri [DEPTH];
  int                       occ;
  logic [MSZ_W-1:0]         max_size;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("spq_checker: %0t %s: got %h, want %h", $time, what, got, want);
    fail_count++;
  endtask

  // advance the queue model by one request, queue up what it must return
  task automatic apply_request(input logic [1:0] cmd,
                               input logic signed [DATA_W-1:0] nv,
                               input logic signed [DATA_W-1:0] np);
    int            cap;
    int            pos;
    int            i;
    queue_result_t r;
    cap = (max_size > DEPTH) ? DEPTH : int'(max_size);
    r = '{STAT_OK, '0, '0, 1'b1};
    case (cmd)
      CMD_INSERT: begin
        if (occ >= cap) begin
          r.status = STAT_FULL;
        end else begin
          pos = 0;
          while (pos < occ && slot_pri[pos] <= np) pos++;
          for (i = occ; i > pos; i--) begin
            slot_val[i] = slot_val[i-1];
            slot_pri[i] = slot_pri[i-1];
          end
          slot_val[pos] = nv;
          slot_pri[pos] = np;
          occ++;
        end
        awaited_q.push_back(r);
      end
      CMD_REMOVE: begin
        if (occ == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.value = slot_val[0];
          r.prio  = slot_pri[0];
          for (i = 0; i + 1 < occ; i++) begin
            slot_val[i] = slot_val[i+1];
            slot_pri[i] = slot_pri[i+1];
          end
          occ--;
        end
        awaited_q.push_back(r);
      end
      CMD_DUMP: begin
        if (occ == 0) begin
          r.status = STAT_EMPTY;
          awaited_q.push_back(r);
        end else begin
          for (i = 0; i < occ; i++) begin
            r.value = slot_val[i];
            r.prio  = slot_pri[i];
            r.last  = (i == occ - 1);
            awaited_q.push_back(r);
          end
        end
      end
      default: ;  // unused command: no result, no state change
    endcase
  endtask

  task automatic check_result();
    queue_result_t want;
    if (awaited_q.size() == 0) begin
      report("result with nothing awaited, value", out_value, '0);
    end else begin
      want = awaited_q.pop_front();
      if (out_status !== want.status) report("status", out_status, want.status);
      if (out_value !== want.value) report("value", out_value, want.value);
      if (out_priority !== want.prio) report("priority", out_priority, want.prio);
      if (out_last !== want.last) report("last", out_last, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      occ      = 0;
      max_size = MAX_SIZE_RST;
      awaited_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[2] == REG_MAX_SIZE)
        max_size = cfg_pwdata[MSZ_W-1:0];
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) apply_request(in_cmd, in_new_value, in_new_priority);
    end
    pending <= awaited_q.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import spq_pkg::*;

  // Cycle budget. Slowest sane run: ~230 requests, each a 16-entry dump
  // whose results each sit out the longest random stall, plus gaps and
  // scan time, stays well inside this budget with a wide margin.
  localparam int LIMIT       = 1_000_000;
  // Longest single request: insert past 15 entries or remove from 16.
  localparam int SETTLE      = 40;
  // Long receiver hold-off that lets the block back up into its input.
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 9;
  localparam int PER_PHASE   = 21;

  // command code with no operation behind it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_cmd = CMD_INSERT;
  logic signed [DATA_W-1:0] in_new_value = '0;
  logic signed [DATA_W-1:0] in_new_priority = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_value;
  logic signed [DATA_W-1:0] out_priority;
  logic                     out_last;

  logic                     cfg_psel = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite = 1'b0;
  logic [2:0]               cfg_paddr = '0;
  logic [31:0]              cfg_pwdata = '0;
  logic [31:0]              cfg_prdata;
  logic                     cfg_pready;

  int                       fail_count;
  int                       pending;

  // knobs shared between the request and result sides
  bit                       gaps_on = 1'b0;
  bit                       stall_on = 1'b0;
  bit                       hold_req = 1'b0;

  sorted_priority_queue_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_new_value   (in_new_value),
    .in_new_priority(in_new_priority),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_value      (out_value),
    .out_priority   (out_priority),
    .out_last       (out_last),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  spq_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_new_value   (in_new_value),
    .in_new_priority(in_new_priority),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_value      (out_value),
    .out_priority   (out_priority),
    .out_last       (out_last),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none, else drawn from a short, a middle or a long range, the longer ones rarer.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Priorities: a narrow band around zero to force ties (stable insert order),
  // the signed extremes, minus one and zero, and plain random words.
  function automatic logic [31:0] pick_prio();
    case ($urandom_range(3))
      0: return 32'($urandom_range(6)) - 32'd3;
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Result side: no back-pressure, random back-pressure, or one long hold-off on request.
  initial begin : result_side
    int n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!stall_on) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n == 0) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  // Offer one request and hold it until the block takes it, then maybe idle.
  task automatic send(input logic [1:0] cmd, input logic [31:0] val, input logic [31:0] prio);
    int gap;
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_new_value    <= val;
    in_new_priority <= prio;
    do @(posedge clk); while (in_stall);
    if (gaps_on) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_random(input int ins_pct);
    int         r;
    logic [1:0] cmd;
    r = $urandom_range(99);
    if (r < ins_pct) cmd = CMD_INSERT;
    else if (r >= 96) cmd = CMD_UNUSED;  // must be ignored
    else if (r >= 84) cmd = CMD_DUMP;
    else cmd = CMD_REMOVE;
    send(cmd, $urandom, pick_prio());
  endtask

  // Stop offering, wait until every awaited result is back, then let the
  // last request finish inside the block (a remove still shifts after its result).
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready.
  task automatic write_max_size(input logic [MSZ_W-1:0] size);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {REG_MAX_SIZE, 2'b00};
    cfg_pwdata  <= 32'(size);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Capacity plan: full depth, zero (below occupancy), one, above depth,
  // small odd sizes, full depth again, the reset value, then a random one.
  function automatic logic [MSZ_W-1:0] cap_for_phase(input int k);
    case (k)
      0: return 5'd16;
      1: return 5'd0;
      2: return 5'd1;
      3: return 5'd31;
      4: return 5'd3;
      5: return 5'd7;
      6: return 5'd16;
      7: return MAX_SIZE_RST;
      default: return 5'($urandom_range(31));
    endcase
  endfunction

  initial begin : watchdog
    repeat (LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int i;
    int k;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass at the reset capacity of 10, back to back, no stalls.
    send(CMD_REMOVE, '0, '0);                    // remove on empty
    send(CMD_DUMP, '0, '0);                      // dump on empty
    send(CMD_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(CMD_INSERT, 32'h8000_0000, 32'h8000_0000);
    send(CMD_INSERT, 32'h0000_0001, 32'h0000_0000);
    send(CMD_INSERT, 32'h0000_0002, 32'h0000_0000); // tie: goes after the first
    send(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(CMD_UNUSED, $urandom, $urandom);        // ignored, no result
    send(CMD_DUMP, '0, '0);
    send(CMD_REMOVE, '0, '0);
    for (i = 0; i < 6; i++) send(CMD_INSERT, 32'(i), 32'(i * 3 - 7));
    send(CMD_INSERT, 32'h1234_5678, 32'h0000_0000); // queue full
    send(CMD_DUMP, '0, '0);

    // Random phases, one capacity each; config only written with the block idle.
    for (k = 0; k < PHASES; k++) begin
      gaps_on  = (k % 3 != 1);
      stall_on = (k % 3 != 2);
      drain();
      write_max_size(cap_for_phase(k));
      for (i = 0; i < PER_PHASE; i++) begin
        send_random(k == 1 ? 35 : 62);
        // sender pause: wait for every awaited result mid-phase
        if (i == PER_PHASE / 2 && k % 2 == 0) drain();
      end
      if (k == 0) begin
        // Receiver holds off while requests keep coming back to back,
        // so the block backs up and stalls its input.
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        for (i = 0; i < 24; i++) send_random(70);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
src/spq_pkg.sv
src/spq_ram.sv
src/sorted_priority_queue_core.sv
tb/sv/spq_checker.sv
tb/sv/tb.sv
